// ----- rtl/block_rms_level_macros.svh -----
// Assertion helpers for the block_rms_level checker.
`ifndef BLOCK_RMS_LEVEL_MACROS_SVH
`define BLOCK_RMS_LEVEL_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define RMSL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked check that also holds through reset.
`define RMSL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- rtl/rmsl_pkg.sv -----
`default_nettype none
package rmsl_pkg;

    localparam int SAMPLE_W           = 16;
    localparam int RMS_W              = SAMPLE_W;
    localparam int SQUARE_W           = 2 * SAMPLE_W;
    localparam int MAX_BLOCK_LOG2_DEF = 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic              nonempty;
        logic [QLVL_W-1:0] level;
    } rmsl_qstat_t;

endpackage
`default_nettype wire

// ----- rtl/rmsl_front.sv -----
`default_nettype none
module rmsl_front #(
    parameter int MAX_BLOCK_LOG2 = rmsl_pkg::MAX_BLOCK_LOG2_DEF,
    parameter int CNT_W          = MAX_BLOCK_LOG2 + 1,
    parameter int SUM_W          = rmsl_pkg::SQUARE_W + MAX_BLOCK_LOG2
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_valid,
    output logic                              s_ready,
    input  wire signed [rmsl_pkg::SAMPLE_W-1:0] s_sample,
    input  wire                               s_last,
    input  rmsl_pkg::rmsl_qstat_t             q_stat,
    output logic                              push,
    output logic [SUM_W-1:0]                  push_sum,
    output logic [CNT_W-1:0]                  push_cnt,
    output logic                              push_ovf
);

    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(1) << MAX_BLOCK_LOG2;

    logic                              accept;
    logic                              sat;
    logic [CNT_W-1:0]                  cnt_after;
    logic                              ovf_after;
    logic signed [rmsl_pkg::SQUARE_W-1:0] product;
    logic [rmsl_pkg::SQUARE_W-1:0]     addend;
    logic [SUM_W-1:0]                  sum_total;
    logic [rmsl_pkg::QLVL_W:0]         committed;

    logic [CNT_W-1:0]                  count_reg, count_next;
    logic                              ovf_reg, ovf_next;
    logic                              s1_valid_reg;
    logic                              s1_last_reg;
    logic                              s1_add_reg;
    logic [rmsl_pkg::SQUARE_W-1:0]     s1_sq_reg;
    logic [CNT_W-1:0]                  s1_cnt_reg;
    logic                              s1_ovf_reg;
    logic [SUM_W-1:0]                  sum_reg, sum_next;

    // Leave room in the queue for a block end still in flight.
    assign committed = {1'b0, q_stat.level} + {{rmsl_pkg::QLVL_W{1'b0}},
                                               (s1_valid_reg & s1_last_reg)};
    assign s_ready   = (committed < (rmsl_pkg::QLVL_W + 1)'(rmsl_pkg::QUEUE_DEPTH));
    assign accept    = s_valid & s_ready;

    assign sat       = (count_reg == LIMIT);
    assign cnt_after = sat ? count_reg : count_reg + 1'b1;
    assign ovf_after = ovf_reg | sat;
    assign product   = s_sample * s_sample;

    always_comb begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (accept) begin
            count_next = s_last ? '0 : cnt_after;
            ovf_next   = s_last ? 1'b0 : ovf_after;
        end
    end

    assign addend    = s1_add_reg ? s1_sq_reg : '0;
    assign sum_total = sum_reg + SUM_W'(addend);

    always_comb begin
        sum_next = sum_reg;
        if (s1_valid_reg) begin
            sum_next = s1_last_reg ? '0 : sum_total;
        end
    end

    assign push     = s1_valid_reg & s1_last_reg;
    assign push_sum = sum_total;
    assign push_cnt = s1_cnt_reg;
    assign push_ovf = s1_ovf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            s1_valid_reg <= 1'b0;
            sum_reg      <= '0;
        end else begin
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            s1_valid_reg <= accept;
            sum_reg      <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_last_reg <= s_last;
            s1_add_reg  <= ~sat;
            s1_sq_reg   <= $unsigned(product);
            s1_cnt_reg  <= cnt_after;
            s1_ovf_reg  <= ovf_after;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/rmsl_queue.sv -----
`default_nettype none
module rmsl_queue #(
    parameter int ENT_W = 66
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    push,
    input  wire  [ENT_W-1:0]       push_data,
    input  wire                    pop,
    output logic [ENT_W-1:0]       pop_data,
    output rmsl_pkg::rmsl_qstat_t  q_stat
);

    localparam logic [rmsl_pkg::QPTR_W-1:0] LAST_SLOT =
        rmsl_pkg::QPTR_W'(rmsl_pkg::QUEUE_DEPTH - 1);

    logic [ENT_W-1:0]              mem_reg [rmsl_pkg::QUEUE_DEPTH];
    logic [rmsl_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [rmsl_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [rmsl_pkg::QLVL_W-1:0]   level_reg, level_next;

    assign wr_ptr_next = !push ? wr_ptr_reg :
                         (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = !pop ? rd_ptr_reg :
                         (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;

    always_comb begin
        level_next = level_reg;
        if (push && !pop) begin
            level_next = level_reg + 1'b1;
        end else if (pop && !push) begin
            level_next = level_reg - 1'b1;
        end
    end

    assign pop_data        = mem_reg[rd_ptr_reg];
    assign q_stat.nonempty = (level_reg != '0);
    assign q_stat.level    = level_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/rmsl_back.sv -----
`default_nettype none
module rmsl_back #(
    parameter int MAX_BLOCK_LOG2 = rmsl_pkg::MAX_BLOCK_LOG2_DEF,
    parameter int CNT_W          = MAX_BLOCK_LOG2 + 1,
    parameter int SUM_W          = rmsl_pkg::SQUARE_W + MAX_BLOCK_LOG2
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  rmsl_pkg::rmsl_qstat_t         q_stat,
    output logic                          pop,
    input  wire  [SUM_W-1:0]              pop_sum,
    input  wire  [CNT_W-1:0]              pop_cnt,
    input  wire                           pop_ovf,
    output logic                          m_valid,
    input  wire                           m_ready,
    output logic [rmsl_pkg::RMS_W-1:0]    m_rms_value,
    output logic [CNT_W-1:0]              m_sample_total,
    output logic                          m_overflow
);

    localparam int RT_W   = rmsl_pkg::RMS_W;
    localparam int RAD_W  = rmsl_pkg::SQUARE_W;
    localparam int STEP_W = $clog2(SUM_W);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_ROOT = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [SUM_W-1:0]    quo_reg, quo_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]    div_reg, div_next;
    logic [CNT_W-1:0]    total_reg, total_next;
    logic                ovf_reg, ovf_next;
    logic [RAD_W-1:0]    rad_reg, rad_next;
    logic [RT_W+1:0]     srem_reg, srem_next;
    logic [RT_W-1:0]     root_reg, root_next;

    logic [CNT_W:0]      rem_sh;
    logic                qbit;
    logic [CNT_W:0]      rem_sub;
    logic [SUM_W-1:0]    quo_shift;
    logic [RT_W+3:0]     srem_sh;
    logic [RT_W+3:0]     trial;
    logic                rbit;
    logic [RT_W+3:0]     srem_sub;

    // One quotient bit per cycle, restoring.
    assign rem_sh    = {rem_reg, quo_reg[SUM_W-1]};
    assign qbit      = (rem_sh >= {1'b0, div_reg});
    assign rem_sub   = rem_sh - {1'b0, div_reg};
    assign quo_shift = {quo_reg[SUM_W-2:0], qbit};

    // One root bit per cycle, two radicand bits brought down each step.
    assign srem_sh  = {srem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial    = {2'b00, root_reg, 2'b01};
    assign rbit     = (srem_sh >= trial);
    assign srem_sub = srem_sh - trial;

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        total_next = total_reg;
        ovf_next   = ovf_reg;
        rad_next   = rad_reg;
        srem_next  = srem_reg;
        root_next  = root_reg;
        pop        = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_stat.nonempty) begin
                    pop        = 1'b1;
                    quo_next   = pop_sum;
                    rem_next   = '0;
                    div_next   = pop_cnt;
                    total_next = pop_cnt;
                    ovf_next   = pop_ovf;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                quo_next = quo_shift;
                rem_next = qbit ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(SUM_W - 1)) begin
                    rad_next   = quo_shift[RAD_W-1:0];
                    srem_next  = '0;
                    root_next  = '0;
                    step_next  = '0;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
                srem_next = rbit ? srem_sub[RT_W+1:0] : srem_sh[RT_W+1:0];
                root_next = {root_reg[RT_W-2:0], rbit};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(RT_W - 1)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid        = (state_reg == ST_OUT);
    assign m_rms_value    = root_reg;
    assign m_sample_total = total_reg;
    assign m_overflow     = ovf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
        total_reg <= total_next;
        ovf_reg   <= ovf_next;
        rad_reg   <= rad_next;
        srem_reg  <= srem_next;
        root_reg  <= root_next;
    end

endmodule
`default_nettype wire

// ----- rtl/block_rms_level.sv -----
// Channel   Ports                                   Direction  Moves
// s_        s_valid s_ready s_sample s_last         in         one sample per transaction
// m_        m_valid m_ready m_rms_value             out        one block result per transaction
//           m_sample_total m_overflow
//
// Samples: one transaction per cycle while the result queue has room.
// Block end: the back end pops the block, runs the bit-serial divider and then the
//   bit-serial root, and only then offers the result.
// Reset: synchronous, active low; clears counters, accumulator and queue.
// Stalls: s_ready drops only when the two-entry block queue would fill.
`default_nettype none
module block_rms_level #(
    parameter int MAX_BLOCK_LOG2 = rmsl_pkg::MAX_BLOCK_LOG2_DEF
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  wire signed [rmsl_pkg::SAMPLE_W-1:0]  s_sample,
    input  wire                                  s_last,
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output logic [rmsl_pkg::RMS_W-1:0]           m_rms_value,
    output logic [MAX_BLOCK_LOG2:0]              m_sample_total,
    output logic                                 m_overflow
);

    // Count needs one extra bit to hold the saturated length itself.
    localparam int CNT_W = MAX_BLOCK_LOG2 + 1;
    // Sum of up to 2^MAX_BLOCK_LOG2 squares, each at most 2^30: exact.
    localparam int SUM_W = rmsl_pkg::SQUARE_W + MAX_BLOCK_LOG2;
    localparam int ENT_W = SUM_W + CNT_W + 1;

    rmsl_pkg::rmsl_qstat_t q_stat;

    logic               push;
    logic [SUM_W-1:0]   push_sum;
    logic [CNT_W-1:0]   push_cnt;
    logic               push_ovf;
    logic               pop;
    logic [ENT_W-1:0]   pop_data;

    // Front end: square each sample, accumulate, snapshot the block on its last transaction.
    rmsl_front #(
        .MAX_BLOCK_LOG2 (MAX_BLOCK_LOG2),
        .CNT_W          (CNT_W),
        .SUM_W          (SUM_W)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_sample (s_sample),
        .s_last   (s_last),
        .q_stat   (q_stat),
        .push     (push),
        .push_sum (push_sum),
        .push_cnt (push_cnt),
        .push_ovf (push_ovf)
    );

    // Hold finished block totals until the back end is free.
    rmsl_queue #(
        .ENT_W (ENT_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({push_sum, push_cnt, push_ovf}),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    // Back end: divide by the count, take the floor root, present the result.
    rmsl_back #(
        .MAX_BLOCK_LOG2 (MAX_BLOCK_LOG2),
        .CNT_W          (CNT_W),
        .SUM_W          (SUM_W)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_stat         (q_stat),
        .pop            (pop),
        .pop_sum        (pop_data[ENT_W-1 -: SUM_W]),
        .pop_cnt        (pop_data[CNT_W:1]),
        .pop_ovf        (pop_data[0]),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_rms_value    (m_rms_value),
        .m_sample_total (m_sample_total),
        .m_overflow     (m_overflow)
    );

endmodule
`default_nettype wire

// ----- rtl/rmsl_checker.sv -----
`default_nettype none
`include "block_rms_level_macros.svh"
module rmsl_checker #(
    parameter int MAX_BLOCK_LOG2 = rmsl_pkg::MAX_BLOCK_LOG2_DEF
) (
    input wire                                  aclk,
    input wire                                  aresetn,
    input wire                                  s_valid,
    input wire                                  s_ready,
    input wire signed [rmsl_pkg::SAMPLE_W-1:0]  s_sample,
    input wire                                  s_last,
    input wire                                  m_valid,
    input wire                                  m_ready,
    input wire [rmsl_pkg::RMS_W-1:0]            m_rms_value,
    input wire [MAX_BLOCK_LOG2:0]               m_sample_total,
    input wire                                  m_overflow
);

    localparam int CNT_W = MAX_BLOCK_LOG2 + 1;
    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(1) << MAX_BLOCK_LOG2;

    `RMSL_ASSERT(a_result_hold, m_valid && !m_ready |=> m_valid && $stable(m_rms_value) && $stable(m_sample_total) && $stable(m_overflow), "result changed while stalled")
    `RMSL_ASSERT(a_total_range, m_valid |-> (m_sample_total != '0) && (m_sample_total <= LIMIT), "sample total out of range")
    `RMSL_ASSERT(a_ovf_saturated, m_valid && m_overflow |-> m_sample_total == LIMIT, "overflow without saturated count")
    `RMSL_ASSERT_ALWAYS(a_reset_quiet, !aresetn |=> !m_valid, "result offered after reset")

endmodule

bind block_rms_level rmsl_checker #(
    .MAX_BLOCK_LOG2 (MAX_BLOCK_LOG2)
) u_rmsl_checker (.*);
`default_nettype wire
